>>> rtl/pmac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphase MAC package
// Shared types and constants for the four-channel resampler tap accumulator.
// ----------------------------------------------------------------------------
package pmac_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int WORD_W       = 16;

	// filter_mode register codes
	localparam logic [1:0] MODE_VERT     = 2'd0;
	localparam logic [1:0] MODE_HORIZ    = 2'd1;
	localparam logic [1:0] MODE_COLLAPSE = 2'd2;
	localparam logic [1:0] MODE_RSVD     = 2'd3;

	typedef logic [1:0] mode_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] chan_a;
		logic signed [WORD_W-1:0] chan_b;
		logic signed [WORD_W-1:0] chan_c;
		logic signed [WORD_W-1:0] chan_d;
		logic signed [WORD_W-1:0] tap_weight;
		logic                     last_tap;
	} tap_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] res_a;
		logic signed [WORD_W-1:0] res_b;
		logic signed [WORD_W-1:0] res_c;
		logic signed [WORD_W-1:0] res_d;
	} res_t;

	// Control bundle from the top level to each lane.
	typedef struct packed {
		logic  step;
		mode_t mode;
		logic  last_tap;
	} lane_ctl_t;

endpackage : pmac_pkg
`default_nettype wire

>>> rtl/pmac_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphase MAC lane
// One channel: Q15 multiply, saturating accumulate and output formatting.
// ----------------------------------------------------------------------------
module pmac_lane (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pmac_pkg::lane_ctl_t            ctl,
	input  wire logic signed [pmac_pkg::WORD_W-1:0] chan,
	input  wire logic signed [pmac_pkg::WORD_W-1:0] weight,
	output logic signed [pmac_pkg::WORD_W-1:0]      result
);
	import pmac_pkg::*;

	logic signed [WORD_W-1:0]   sum_q;
	logic signed [WORD_W-1:0]   operand;
	logic signed [2*WORD_W-1:0] product;
	logic signed [WORD_W-1:0]   prod_hi;
	logic signed [WORD_W:0]     sum_wide;
	logic signed [WORD_W-1:0]   sum_sat;
	logic signed [WORD_W-1:0]   sum_shr;
	logic signed [WORD_W-1:0]   chan_shr;
	logic                       vertical;
	logic                       collapse;

	// Clamp a signed word to the byte range 0..255.
	function automatic logic [WORD_W-1:0] clamp_byte(input logic signed [WORD_W-1:0] v);
		logic [WORD_W-1:0] r;
		if (v[WORD_W-1]) begin
			r = '0;
		end else if (|v[WORD_W-2:8]) begin
			r = WORD_W'(255);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign vertical = (ctl.mode == MODE_VERT);
	assign collapse = (ctl.mode == MODE_COLLAPSE) || (ctl.mode == MODE_RSVD);

	// Vertical mode doubles the channel first, wrapping within the word.
	assign operand  = vertical ? {chan[WORD_W-2:0], 1'b0} : chan;
	assign product  = operand * weight;
	assign prod_hi  = product[2*WORD_W-1:WORD_W];
	assign sum_wide = {sum_q[WORD_W-1], sum_q} + {prod_hi[WORD_W-1], prod_hi};

	always_comb begin
		if (sum_wide[WORD_W] != sum_wide[WORD_W-1]) begin
			sum_sat = sum_wide[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}}
			                           : {1'b0, {(WORD_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[WORD_W-1:0];
		end
	end

	assign sum_shr  = sum_sat >>> 4;
	assign chan_shr = chan >>> 5;

	always_comb begin
		if (collapse) begin
			result = clamp_byte(chan_shr);
		end else if (vertical) begin
			result = sum_sat;
		end else begin
			result = clamp_byte(sum_shr);
		end
	end

	// Collapse mode passes pixels through and leaves the sum untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.step && !collapse) begin
			sum_q <= ctl.last_tap ? '0 : sum_sat;
		end
	end

endmodule : pmac_lane
`default_nettype wire

>>> rtl/polyphase_four_channel_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphase four-channel MAC
// Accumulates Q15-weighted filter taps per channel and emits one pixel per
// last tap, or one byte pixel per tap in collapse mode.
// ----------------------------------------------------------------------------
// Path: a tap is captured in the input register, then its result is loaded
// into the result register behind the lane arithmetic.
// Throughput: one tap per cycle; the input stalls only while a finished
// result is held by a stalled output.
// Reset: arst_n clears the sums, filter_mode and all valid flags at once.
module polyphase_four_channel_mac (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             tap_valid,
	output logic                  tap_stall,
	input  wire pmac_pkg::tap_t   tap,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output pmac_pkg::res_t        res,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire pmac_pkg::mode_t  cfg_data
);
	import pmac_pkg::*;

	mode_t     mode_q;
	logic      valid_s1;
	tap_t      tap_s1;
	logic      collapse;
	logic      produces;
	logic      out_free;
	logic      advance;
	logic      accept;
	lane_ctl_t lane_ctl;
	res_t      res_q;
	logic      res_valid_q;

	logic signed [WORD_W-1:0] chan_s1  [NUM_CHANNELS];
	logic signed [WORD_W-1:0] lane_res [NUM_CHANNELS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_VERT;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign collapse = (mode_q == MODE_COLLAPSE) || (mode_q == MODE_RSVD);
	assign produces = collapse || tap_s1.last_tap;
	assign out_free = !res_valid_q || !res_stall;
	assign advance  = valid_s1 && (!produces || out_free);
	assign tap_stall = valid_s1 && !advance;
	assign accept   = tap_valid && !tap_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tap_s1 <= tap;
		end
	end

	assign chan_s1[0] = tap_s1.chan_a;
	assign chan_s1[1] = tap_s1.chan_b;
	assign chan_s1[2] = tap_s1.chan_c;
	assign chan_s1[3] = tap_s1.chan_d;

	assign lane_ctl.step     = advance;
	assign lane_ctl.mode     = mode_q;
	assign lane_ctl.last_tap = tap_s1.last_tap;

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
		pmac_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.chan   (chan_s1[i]),
			.weight (tap_s1.tap_weight),
			.result (lane_res[i])
		);
	end

	// The result register is loaded only when it is empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && produces) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			res_q.res_a <= lane_res[0];
			res_q.res_b <= lane_res[1];
			res_q.res_c <= lane_res[2];
			res_q.res_d <= lane_res[3];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A stall toward the source only ever holds back a pending tap.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		tap_stall |-> valid_s1)
		else $error("input stalled with no tap held");

	// A tap that produces a result must show up on the output next cycle.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && produces) |=> res_valid)
		else $error("result transfer lost");

	// With no new tap, the held tap drains once it moves on.
	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !tap_valid) |=> !valid_s1)
		else $error("input stage kept a consumed tap");

	// A held result that is stalled may not be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> !(advance && produces))
		else $error("stalled result overwritten");

endmodule : polyphase_four_channel_mac
`default_nettype wire

>>> bench/tb_polyphase_four_channel_mac.sv
// ----------------------------------------------------------------------------
// Testbench for the polyphase four-channel MAC
// Streams filter taps into the block in every filter mode and checks each
// emitted pixel against a local predictor of the tap accumulator. The input
// idles and the output stalls at random; filter mode changes between phases.
// ----------------------------------------------------------------------------
module tb_polyphase_four_channel_mac;
	import pmac_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  tap_valid = 1'b0;
	logic  tap_stall;
	tap_t  tap       = '0;
	logic  res_valid;
	logic  res_stall = 1'b0;
	res_t  res;
	logic  cfg_valid = 1'b0;
	logic  cfg_ready;
	mode_t cfg_data  = MODE_VERT;

	// Predictor state: the running sums and the mode in force.
	logic signed [15:0] acc_sums [4];
	mode_t              cur_mode;
	res_t               pending_pixels [$];

	int err_count    = 0;
	int pixel_count  = 0;
	int cycle_count  = 0;
	int burst_left   = 0;
	int stall_style  = 0;
	int stall_left   = 0;

	polyphase_four_channel_mac dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tap_valid (tap_valid),
		.tap_stall (tap_stall),
		.tap       (tap),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_polyphase_four_channel_mac: errors");
			$finish;
		end
	end

	// Output stall pattern: phases of no stall, light, heavy and periodic stall.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_left  <= $urandom_range(20, 150);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			2: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= cycle_count[2];
		endcase
	end

	function automatic logic signed [15:0] to_byte(input logic signed [15:0] v);
		if (v < 0)
			return 16'sd0;
		if (v > 255)
			return 16'sd255;
		return v;
	endfunction

	// Applies one tap to the predicted sums; returns 1 when a pixel comes out.
	function automatic bit accumulate_tap(input tap_t t, output res_t px);
		logic signed [15:0] chans [4];
		logic signed [15:0] outs [4];
		logic signed [15:0] w;
		logic signed [15:0] word;
		logic signed [31:0] prod;
		logic signed [16:0] total;
		bit                 vertical;
		int                 i;
		chans[0] = t.chan_a;
		chans[1] = t.chan_b;
		chans[2] = t.chan_c;
		chans[3] = t.chan_d;
		w        = t.tap_weight;
		vertical = (cur_mode == MODE_VERT);
		px       = '0;
		if (cur_mode[1]) begin
			for (i = 0; i < 4; i++)
				outs[i] = to_byte(chans[i] >>> 5);
			px = {outs[0], outs[1], outs[2], outs[3]};
			return 1'b1;
		end
		for (i = 0; i < 4; i++) begin
			// Vertical taps are doubled first, wrapping within the word.
			word  = vertical ? {chans[i][14:0], 1'b0} : chans[i];
			prod  = word * w;
			total = acc_sums[i] + $signed(prod[31:16]);
			if (total[16] != total[15])
				acc_sums[i] = total[16] ? 16'sh8000 : 16'sh7fff;
			else
				acc_sums[i] = total[15:0];
		end
		if (!t.last_tap)
			return 1'b0;
		for (i = 0; i < 4; i++) begin
			outs[i]     = vertical ? acc_sums[i] : to_byte(acc_sums[i] >>> 4);
			acc_sums[i] = '0;
		end
		px = {outs[0], outs[1], outs[2], outs[3]};
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("ERROR @%0d: %s", cycle_count, msg);
		err_count++;
	endtask

	always @(posedge clk) begin : check_pixels
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_pixels.size() == 0) begin
				flag_mismatch($sformatf("unexpected pixel %h", res));
			end else begin
				want = pending_pixels.pop_front();
				if (res.res_a !== want.res_a)
					flag_mismatch($sformatf("pixel %0d res_a %h, want %h",
						pixel_count, res.res_a, want.res_a));
				if (res.res_b !== want.res_b)
					flag_mismatch($sformatf("pixel %0d res_b %h, want %h",
						pixel_count, res.res_b, want.res_b));
				if (res.res_c !== want.res_c)
					flag_mismatch($sformatf("pixel %0d res_c %h, want %h",
						pixel_count, res.res_c, want.res_c));
				if (res.res_d !== want.res_d)
					flag_mismatch($sformatf("pixel %0d res_d %h, want %h",
						pixel_count, res.res_d, want.res_d));
			end
			pixel_count++;
		end
	end

	function automatic tap_t make_tap(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d, input logic [15:0] w,
			input logic last);
		tap_t t;
		t.chan_a     = a;
		t.chan_b     = b;
		t.chan_c     = c;
		t.chan_d     = d;
		t.tap_weight = w;
		t.last_tap   = last;
		return t;
	endfunction

	// Mix of extremes, full-range words and small magnitudes of either sign.
	function automatic logic [15:0] rand_word();
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 16'h7fff;
					1: v = 16'h8000;
					2: v = 16'h0000;
					default: v = 16'hffff;
				endcase
			end
			1, 2, 3: v = 16'($urandom_range(0, 65535));
			default: begin
				v = 16'($urandom_range(0, 65535) >> $urandom_range(3, 12));
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic tap_t rand_tap(input logic last);
		return make_tap(rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word(), last);
	endfunction

	// Sends one tap in the current burst, possibly opening a gap between bursts.
	task automatic send_tap(input tap_t t);
		res_t px;
		int   gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				tap_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		tap       <= t;
		tap_valid <= 1'b1;
		@(posedge clk);
		while (tap_stall)
			@(posedge clk);
		if (accumulate_tap(t, px))
			pending_pixels.push_back(px);
	endtask

	// Holds the input until every expected pixel is out and the pipe is empty.
	task automatic wait_drained();
		tap_valid  <= 1'b0;
		burst_left = 0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input mode_t m);
		wait_drained();
		cfg_data  <= m;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_mode  = m;
	endtask

	task automatic test_vertical_directed();
		write_mode(MODE_VERT);
		send_tap(make_tap(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1));
		send_tap(make_tap(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
		// Four heavy negative taps drive every sum into negative saturation.
		repeat (3)
			send_tap(make_tap(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h7fff, 1'b0));
		send_tap(make_tap(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h7fff, 1'b1));
		repeat (2)
			send_tap(make_tap(16'hc000, 16'h3fff, 16'h0000, 16'hffff, 16'h8000, 1'b0));
		send_tap(make_tap(16'hc000, 16'h3fff, 16'h0000, 16'hffff, 16'h8000, 1'b1));
		send_tap(make_tap(16'hffff, 16'h0001, 16'h8001, 16'h7ffe, 16'h0001, 1'b1));
	endtask

	task automatic test_horizontal_directed();
		write_mode(MODE_HORIZ);
		send_tap(make_tap(16'h7fff, 16'h8000, 16'h1000, 16'hf000, 16'h7fff, 1'b1));
		send_tap(make_tap(16'h0800, 16'hf800, 16'h0100, 16'h2000, 16'h4000, 1'b0));
		send_tap(make_tap(16'h0800, 16'hf800, 16'h0100, 16'h2000, 16'h4000, 1'b1));
		repeat (2)
			send_tap(make_tap(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0));
		send_tap(make_tap(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1));
	endtask

	task automatic test_collapse_directed();
		write_mode(MODE_COLLAPSE);
		send_tap(make_tap(16'h7fff, 16'h8000, 16'h1fff, 16'h0020, 16'h1234, 1'b0));
		send_tap(make_tap(16'h001f, 16'hffe0, 16'h2000, 16'h0000, 16'h8000, 1'b1));
		// The unused mode code behaves as collapse.
		write_mode(MODE_RSVD);
		send_tap(make_tap(16'h7fff, 16'h8000, 16'h1fff, 16'h0040, 16'h7fff, 1'b0));
		send_tap(make_tap(16'h0fe0, 16'hffff, 16'h3000, 16'h0001, 16'h0000, 1'b1));
	endtask

	// Sums built in vertical mode survive a collapse item and are emitted in
	// horizontal format by the next last tap.
	task automatic test_mode_change_mid_pixel();
		write_mode(MODE_VERT);
		repeat (2)
			send_tap(make_tap(16'h0400, 16'h0100, 16'hfc00, 16'h0010, 16'h7fff, 1'b0));
		write_mode(MODE_COLLAPSE);
		send_tap(make_tap(16'h0a00, 16'hf600, 16'h00ff, 16'h7001, 16'h7fff, 1'b1));
		write_mode(MODE_HORIZ);
		send_tap(make_tap(16'h0000, 16'h0100, 16'h0000, 16'h0200, 16'h7fff, 1'b1));
	endtask

	// Well-formed pixels with random content, plus stray taps as noise.
	task automatic test_random_filtering(input mode_t m, input int pixels);
		int p;
		int n;
		int k;
		write_mode(m);
		for (p = 0; p < pixels; p++) begin
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_tap(rand_tap(1'($urandom_range(0, 1))));
				send_tap(rand_tap(k == n - 1));
			end
			if ($urandom_range(0, 30) == 0)
				wait_drained();
		end
	endtask

	task automatic test_random_collapse(input mode_t m, input int items);
		int k;
		write_mode(m);
		for (k = 0; k < items; k++) begin
			send_tap(rand_tap(1'($urandom_range(0, 1))));
			if ($urandom_range(0, 60) == 0)
				wait_drained();
		end
	endtask

	initial begin
		cur_mode = MODE_VERT;
		for (int i = 0; i < 4; i++)
			acc_sums[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_vertical_directed();
		test_horizontal_directed();
		test_collapse_directed();
		test_mode_change_mid_pixel();
		test_random_filtering(MODE_VERT, 80);
		test_random_filtering(MODE_HORIZ, 80);
		test_random_collapse(MODE_COLLAPSE, 140);
		test_random_collapse(MODE_RSVD, 90);
		test_random_filtering(MODE_VERT, 25);

		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("tb_polyphase_four_channel_mac: clean");
		else
			$display("tb_polyphase_four_channel_mac: errors");
		$finish;
	end

endmodule

>>> polyphase_four_channel_mac.f
rtl/pmac_pkg.sv
rtl/pmac_lane.sv
rtl/polyphase_four_channel_mac.sv
bench/tb_polyphase_four_channel_mac.sv
